// ===== hw/rtl/pbi_pkg.sv =====
// ----------------------------------------------------------------------------
// pbi_pkg
// Shared types, codes and defaults of the policy bytecode interpreter.
// ----------------------------------------------------------------------------
package pbi_pkg;

  localparam int DEF_NUM_PROGRAMS  = 32;
  localparam int DEF_PROGRAM_DEPTH = 256;
  localparam int DEF_STEP_LIMIT    = 1024;
  localparam int QUEUE_DEPTH       = 2;

  localparam int IN_DATA_W  = 96;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 104;
  localparam int INSTR_W    = 36;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_COMMIT = 2'd1,
    CMD_EXEC   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    K_NOP,
    K_WRITE,
    K_COMMIT,
    K_EXEC,
    K_BADID
  } kind_e;

  typedef enum logic [3:0] {
    OP_NOP        = 4'd0,
    OP_CAP_MATCH  = 4'd1,
    OP_SET_FLAG   = 4'd2,
    OP_CMP_EQ     = 4'd3,
    OP_CMP_LT     = 4'd4,
    OP_CMP_GT     = 4'd5,
    OP_JUMP       = 4'd6,
    OP_JUMP_IF    = 4'd7,
    OP_JUMP_IFN   = 4'd8,
    OP_GRANT      = 4'd9,
    OP_DENY       = 4'd10,
    OP_MARK       = 4'd11,
    OP_HALT       = 4'd12
  } opcode_e;

  typedef enum logic [1:0] {
    V_DENY  = 2'd0,
    V_ALLOW = 2'd1,
    V_ERROR = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_RUN
  } state_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  idx;
    logic [3:0]  opc;
    logic [31:0] arg;
    logic [8:0]  len;
    logic [5:0]  pid;
    logic [31:0] cap;
  } pbi_item_t;

endpackage

// ===== hw/rtl/pbi_front.sv =====
// ----------------------------------------------------------------------------
// pbi_front
// Input side: takes command transfers, checks index and id, saturates length.
// ----------------------------------------------------------------------------
module pbi_front #(
  parameter int PROGRAM_DEPTH = pbi_pkg::DEF_PROGRAM_DEPTH
) (
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pbi_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [pbi_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output pbi_pkg::pbi_item_t             q_item_o
);
  import pbi_pkg::*;

  logic [7:0]  idx;
  logic [8:0]  plen;
  logic [5:0]  pid;
  kind_e       kind;

  assign idx  = s_axis_tdata[7:0];
  assign plen = s_axis_tdata[52:44];
  assign pid  = s_axis_tdata[58:53];

  always_comb begin
    unique case (cmd_e'(s_axis_tuser))
      CMD_WRITE:  kind = (32'(idx) < 32'(PROGRAM_DEPTH)) ? K_WRITE : K_NOP;
      CMD_COMMIT: kind = K_COMMIT;
      CMD_EXEC:   kind = (pid == 6'd0) ? K_BADID : K_EXEC;
      default:    kind = K_NOP;
    endcase
  end

  always_comb begin
    q_item_o.kind = kind;
    q_item_o.idx  = idx;
    q_item_o.opc  = s_axis_tdata[11:8];
    q_item_o.arg  = s_axis_tdata[43:12];
    q_item_o.len  = (32'(plen) > 32'(PROGRAM_DEPTH)) ? 9'(PROGRAM_DEPTH) : plen;
    q_item_o.pid  = pid;
    q_item_o.cap  = s_axis_tdata[90:59];
  end

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

endmodule

// ===== hw/rtl/pbi_queue.sv =====
// ----------------------------------------------------------------------------
// pbi_queue
// Short command queue between the input side and the execution engine.
// ----------------------------------------------------------------------------
module pbi_queue #(
  parameter int QDEPTH = pbi_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pbi_pkg::pbi_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output pbi_pkg::pbi_item_t item_o
);
  import pbi_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  pbi_item_t         slots_q [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== hw/rtl/pbi_back.sv =====
// ----------------------------------------------------------------------------
// pbi_back
// Execution engine: program store, commits, bytecode sequencer, result register.
// ----------------------------------------------------------------------------
module pbi_back #(
  parameter int NUM_PROGRAMS  = pbi_pkg::DEF_NUM_PROGRAMS,
  parameter int PROGRAM_DEPTH = pbi_pkg::DEF_PROGRAM_DEPTH,
  parameter int STEP_LIMIT    = pbi_pkg::DEF_STEP_LIMIT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  pbi_pkg::pbi_item_t             q_item_i,
  output logic                           q_pop_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [pbi_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import pbi_pkg::*;

  localparam int SLOT_W = (NUM_PROGRAMS > 1) ? $clog2(NUM_PROGRAMS) : 1;
  localparam int CNT_W  = $clog2(NUM_PROGRAMS + 1);
  localparam int LEN_W  = $clog2(PROGRAM_DEPTH + 1);
  localparam int ADDR_W = $clog2(NUM_PROGRAMS * PROGRAM_DEPTH);
  localparam int STEP_W = $clog2(STEP_LIMIT + 1);

  logic [INSTR_W-1:0] store_mem [NUM_PROGRAMS * PROGRAM_DEPTH];
  logic [LEN_W-1:0]   len_mem [NUM_PROGRAMS];

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    committed_q, committed_d;
  logic [31:0]         exec_cnt_q, exec_cnt_d;
  logic [31:0]         err_cnt_q, err_cnt_d;
  logic [31:0]         comp_cnt_q, comp_cnt_d;
  logic [ADDR_W-1:0]   wbase_q, wbase_d;
  logic [ADDR_W-1:0]   rbase_q, rbase_d;
  logic [LEN_W-1:0]    pc_q, pc_d;
  logic [STEP_W-1:0]   steps_q, steps_d;
  logic                flag_q, flag_d;
  verdict_e            verdict_q, verdict_d;
  logic [31:0]         cap_q, cap_d;
  logic                m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;

  logic [INSTR_W-1:0]  instr_q;
  logic [LEN_W-1:0]    len_q;

  logic                st_we, len_we, len_re;
  logic [ADDR_W-1:0]   st_waddr, st_raddr;
  logic [SLOT_W-1:0]   len_waddr, len_raddr;
  logic [5:0]          pid_m1;
  logic                out_free;

  logic                res_valid;
  verdict_e            res_verdict;
  logic [5:0]          res_id;

  opcode_e             op;
  logic [31:0]         arg;
  logic [31:0]         next_pc;
  logic                flag_n;
  verdict_e            verd_n;
  logic                done_ok, done_err;

  assign out_free = !m_valid_q || m_axis_tready;
  assign pid_m1   = q_item_i.pid - 6'd1;
  assign op       = opcode_e'(instr_q[3:0]);
  assign arg      = instr_q[INSTR_W-1:4];

  always_comb begin
    state_d     = state_q;
    committed_d = committed_q;
    exec_cnt_d  = exec_cnt_q;
    err_cnt_d   = err_cnt_q;
    comp_cnt_d  = comp_cnt_q;
    wbase_d     = wbase_q;
    rbase_d     = rbase_q;
    pc_d        = pc_q;
    steps_d     = steps_q;
    flag_d      = flag_q;
    verdict_d   = verdict_q;
    cap_d       = cap_q;
    m_valid_d   = m_axis_tready ? 1'b0 : m_valid_q;
    m_data_d    = m_data_q;
    q_pop_o     = 1'b0;
    st_we       = 1'b0;
    len_we      = 1'b0;
    len_re      = 1'b0;
    st_waddr    = wbase_q + ADDR_W'(q_item_i.idx);
    st_raddr    = rbase_q;
    len_waddr   = SLOT_W'(committed_q);
    len_raddr   = SLOT_W'(pid_m1);
    res_valid   = 1'b0;
    res_verdict = V_DENY;
    res_id      = 6'd0;
    next_pc     = 32'(pc_q) + 32'd1;
    flag_n      = flag_q;
    verd_n      = verdict_q;
    done_ok     = 1'b0;
    done_err    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          unique case (q_item_i.kind)
            K_WRITE: begin
              st_we     = (committed_q < CNT_W'(NUM_PROGRAMS));
              res_valid = 1'b1;
            end
            K_COMMIT: begin
              res_valid = 1'b1;
              if (committed_q >= CNT_W'(NUM_PROGRAMS)) begin
                err_cnt_d   = err_cnt_q + 32'd1;
                res_verdict = V_ERROR;
              end else begin
                len_we      = 1'b1;
                committed_d = committed_q + CNT_W'(1);
                comp_cnt_d  = comp_cnt_q + 32'd1;
                wbase_d     = wbase_q + ADDR_W'(PROGRAM_DEPTH);
                res_id      = 6'(32'(committed_q) + 32'd1);
              end
            end
            K_EXEC: begin
              if (32'(q_item_i.pid) > 32'(committed_q)) begin
                err_cnt_d   = err_cnt_q + 32'd1;
                res_verdict = V_ERROR;
                res_valid   = 1'b1;
              end else begin
                len_re    = 1'b1;
                rbase_d   = ADDR_W'(32'(pid_m1) * 32'(PROGRAM_DEPTH));
                cap_d     = q_item_i.cap;
                flag_d    = 1'b0;
                verdict_d = V_DENY;
                state_d   = S_START;
              end
            end
            K_BADID: begin
              err_cnt_d   = err_cnt_q + 32'd1;
              res_verdict = V_ERROR;
              res_valid   = 1'b1;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_START: begin
        if (len_q == '0) begin
          exec_cnt_d  = exec_cnt_q + 32'd1;
          res_verdict = verdict_q;
          res_valid   = 1'b1;
          state_d     = S_IDLE;
        end else begin
          st_raddr = rbase_q;
          pc_d     = '0;
          steps_d  = STEP_W'(1);
          state_d  = S_RUN;
        end
      end
      S_RUN: begin
        unique case (op) inside
          OP_NOP, OP_MARK:         ;
          OP_CAP_MATCH, OP_CMP_EQ: flag_n = (cap_q == arg);
          OP_SET_FLAG:             flag_n = (arg != 32'd0);
          OP_CMP_LT:               flag_n = (cap_q < arg);
          OP_CMP_GT:               flag_n = (cap_q > arg);
          OP_JUMP:                 next_pc = arg;
          OP_JUMP_IF:              if (flag_q) next_pc = arg;
          OP_JUMP_IFN:             if (!flag_q) next_pc = arg;
          OP_GRANT:                verd_n = V_ALLOW;
          OP_DENY:                 verd_n = V_DENY;
          OP_HALT:                 done_ok = 1'b1;
          default:                 done_err = 1'b1;
        endcase
        if (!done_ok && !done_err) begin
          if (next_pc >= 32'(len_q)) begin
            done_ok = 1'b1;
          end else if (steps_q >= STEP_W'(STEP_LIMIT)) begin
            done_err = 1'b1;
          end else begin
            st_raddr = rbase_q + ADDR_W'(next_pc[LEN_W-1:0]);
            pc_d     = next_pc[LEN_W-1:0];
            steps_d  = steps_q + STEP_W'(1);
          end
        end
        flag_d    = flag_n;
        verdict_d = verd_n;
        if (done_ok) begin
          exec_cnt_d  = exec_cnt_q + 32'd1;
          res_verdict = verd_n;
          res_valid   = 1'b1;
          state_d     = S_IDLE;
        end else if (done_err) begin
          err_cnt_d   = err_cnt_q + 32'd1;
          res_verdict = V_ERROR;
          res_valid   = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (res_valid) begin
      m_valid_d = 1'b1;
      m_data_d  = {comp_cnt_d, err_cnt_d, exec_cnt_d, res_id, res_verdict};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      committed_q <= '0;
      exec_cnt_q  <= '0;
      err_cnt_q   <= '0;
      comp_cnt_q  <= '0;
      wbase_q     <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      committed_q <= committed_d;
      exec_cnt_q  <= exec_cnt_d;
      err_cnt_q   <= err_cnt_d;
      comp_cnt_q  <= comp_cnt_d;
      wbase_q     <= wbase_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rbase_q   <= rbase_d;
    pc_q      <= pc_d;
    steps_q   <= steps_d;
    flag_q    <= flag_d;
    verdict_q <= verdict_d;
    cap_q     <= cap_d;
    m_data_q  <= m_data_d;
  end

  // instruction store
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[st_waddr] <= {q_item_i.arg, q_item_i.opc};
    end
    instr_q <= store_mem[st_raddr];
  end

  // program lengths
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[len_waddr] <= LEN_W'(q_item_i.len);
    end
    if (len_re) begin
      len_q <= len_mem[len_raddr];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== hw/rtl/policy_bytecode_interpreter.sv =====
// ----------------------------------------------------------------------------
// policy_bytecode_interpreter
// Access-policy engine that stores small bytecode programs and runs them
// against capability values.
//
//   channel  dir  tdata (low bit up)                                  tuser
//   s_axis   in   instr_index 8, instr_opcode 4, instr_operand 32,    cmd 2
//                 program_length 9, program_id 6, capability 32, pad 5
//   m_axis   out  verdict 2, assigned_id 6, execution_count 32,       -
//                 error_count 32, compile_count 32
//
// write, commit, unused command, bad id: handled in the idle state, one result each
// execute: an empty program ends in the start state; else the sequencer runs,
//   fetching one instruction per cycle from the program store
// a two-entry queue lets input transfers go on while a program runs
// reset clears counters, committed count and control; store contents undefined
// a result waits in the output register and blocks the engine until taken
// ----------------------------------------------------------------------------
module policy_bytecode_interpreter #(
  parameter int NUM_PROGRAMS  = pbi_pkg::DEF_NUM_PROGRAMS,
  parameter int PROGRAM_DEPTH = pbi_pkg::DEF_PROGRAM_DEPTH,
  parameter int STEP_LIMIT    = pbi_pkg::DEF_STEP_LIMIT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // instr_index, instr_opcode, instr_operand, program_length, program_id, capability
  input  logic [pbi_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // cmd
  input  logic [pbi_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // verdict, assigned_id, execution_count, error_count, compile_count
  output logic [pbi_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import pbi_pkg::*;

  logic      q_push, q_full, q_pop, q_valid;
  pbi_item_t q_in, q_out;

  pbi_front #(
    .PROGRAM_DEPTH(PROGRAM_DEPTH)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (q_in)
  );

  pbi_queue #(
    .QDEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .item_o (q_out)
  );

  pbi_back #(
    .NUM_PROGRAMS (NUM_PROGRAMS),
    .PROGRAM_DEPTH(PROGRAM_DEPTH),
    .STEP_LIMIT   (STEP_LIMIT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_out),
    .q_pop_o      (q_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

// ===== hw/rtl/pbi_checker.sv =====
// ----------------------------------------------------------------------------
// pbi_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pbi_checker #(
  parameter int NUM_PROGRAMS = pbi_pkg::DEF_NUM_PROGRAMS
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [pbi_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import pbi_pkg::*;

  // stalled transfer holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("undefined verdict code");

  // only a successful commit hands out an id, and it reports deny
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[7:2] != 6'd0 |-> m_axis_tdata[1:0] == V_DENY)
    else $error("id given with non-deny verdict");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(m_axis_tdata[7:2]) <= 32'(NUM_PROGRAMS))
    else $error("id beyond program count");

endmodule

bind policy_bytecode_interpreter pbi_checker #(
  .NUM_PROGRAMS(NUM_PROGRAMS)
) u_pbi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ===== tb/sv/tb_policy_bytecode_interpreter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_policy_bytecode_interpreter
// Self-checking bench for the policy bytecode interpreter. Programs are
// written and committed over the input stream, then run against capability
// values. A behavioral predictor tracks the program store and the counters
// and produces the expected response of every transfer. Responses are
// checked in order, field by field. Both stream sides idle and stall at
// random.
// ----------------------------------------------------------------------------
module tb_policy_bytecode_interpreter;
  import pbi_pkg::*;

  localparam int NP           = DEF_NUM_PROGRAMS;
  localparam int PD           = DEF_PROGRAM_DEPTH;
  localparam int SL           = DEF_STEP_LIMIT;
  localparam int RANDOM_ITEMS = 600;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [3:0] OP_BAD_LO  = 4'd13;
  localparam logic [3:0] OP_BAD_HI  = 4'd15;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  idx;
    logic [3:0]  opc;
    logic [31:0] arg;
    logic [8:0]  len;
    logic [5:0]  pid;
    logic [31:0] cap;
  } request_t;

  typedef struct {
    logic [1:0]  verdict;
    logic [5:0]  id;
    logic [31:0] runs;
    logic [31:0] errs;
    logic [31:0] commits;
  } response_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // instr_index, instr_opcode, instr_operand, program_length, program_id, capability
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  // cmd
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // verdict, assigned_id, execution_count, error_count, compile_count
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // predictor state
  logic [3:0]  slot_op  [NP*PD];
  logic [31:0] slot_arg [NP*PD];
  int unsigned slot_len [NP];
  int unsigned slots_used   = 0;
  logic [31:0] runs_done    = '0;
  logic [31:0] err_seen     = '0;
  logic [31:0] commits_done = '0;

  response_t   pending_responses[$];
  logic [31:0] cap_pool[$];
  int          items_sent = 0;
  int          fail_count = 0;
  bit          quiet      = 1'b0;

  policy_bytecode_interpreter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [1:0] evaluate_policy(int unsigned slot, logic [31:0] cap);
    int unsigned base;
    int unsigned pc;
    int unsigned steps;
    logic [3:0]  op;
    logic [31:0] arg;
    bit          flag;
    logic [1:0]  verdict;
    base    = slot * PD;
    pc      = 0;
    steps   = 0;
    flag    = 1'b0;
    verdict = V_DENY;
    while (pc < slot_len[slot]) begin
      if (steps >= SL) begin
        err_seen++;
        return V_ERROR;
      end
      steps++;
      op  = slot_op[base + pc];
      arg = slot_arg[base + pc];
      pc++;
      case (op)
        OP_NOP, OP_MARK: ;
        OP_CAP_MATCH, OP_CMP_EQ: flag = (cap == arg);
        OP_SET_FLAG: flag = (arg != 0);
        OP_CMP_LT: flag = (cap < arg);
        OP_CMP_GT: flag = (cap > arg);
        OP_JUMP: pc = arg;
        OP_JUMP_IF: if (flag) pc = arg;
        OP_JUMP_IFN: if (!flag) pc = arg;
        OP_GRANT: verdict = V_ALLOW;
        OP_DENY: verdict = V_DENY;
        OP_HALT: begin
          runs_done++;
          return verdict;
        end
        default: begin
          err_seen++;
          return V_ERROR;
        end
      endcase
    end
    runs_done++;
    return verdict;
  endfunction

  function automatic response_t predict_response(request_t rq);
    response_t   rs;
    int unsigned a;
    rs.verdict = V_DENY;
    rs.id      = '0;
    case (rq.cmd)
      CMD_WRITE: begin
        if (slots_used < NP && rq.idx < PD) begin
          a           = slots_used * PD + rq.idx;
          slot_op[a]  = rq.opc;
          slot_arg[a] = rq.arg;
        end
      end
      CMD_COMMIT: begin
        if (slots_used >= NP) begin
          err_seen++;
          rs.verdict = V_ERROR;
        end else begin
          slot_len[slots_used] = (rq.len > PD) ? PD : rq.len;
          slots_used++;
          commits_done++;
          rs.id = 6'(slots_used);
        end
      end
      CMD_EXEC: begin
        if (rq.pid == 0 || rq.pid > slots_used) begin
          err_seen++;
          rs.verdict = V_ERROR;
        end else begin
          rs.verdict = evaluate_policy(32'(rq.pid) - 1, rq.cap);
        end
      end
      default: ;
    endcase
    rs.runs    = runs_done;
    rs.errs    = err_seen;
    rs.commits = commits_done;
    return rs;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [31:0] pick_operand();
    int          r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    if (r < 25) v = $urandom_range(0, 15);
    else if (r < 50 && cap_pool.size() > 0) v = cap_pool[$urandom_range(0, cap_pool.size() - 1)];
    else if (r < 60) v = (r < 55) ? 32'h0 : 32'hFFFF_FFFF;
    else v = $urandom;
    cap_pool.push_back(v);
    if (cap_pool.size() > 64) void'(cap_pool.pop_front());
    return v;
  endfunction

  function automatic logic [31:0] pick_capability();
    int          r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    v = $urandom;
    if (cap_pool.size() > 0 && r < 55) begin
      v = cap_pool[$urandom_range(0, cap_pool.size() - 1)];
      if (r >= 40) v = (r < 48) ? v + 1 : v - 1;
    end else if (r < 65) begin
      v = (r < 60) ? 32'h0 : 32'hFFFF_FFFF;
    end else if (r < 75) begin
      v = $urandom_range(0, 15);
    end
    return v;
  endfunction

  function automatic logic [31:0] jump_target(int i, int n, int len_eff);
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return $urandom_range(0, i);
    if (r < 72 && i + 1 < n) return $urandom_range(i + 1, n - 1);
    if (r < 86) return len_eff;
    return $urandom | 32'h100;
  endfunction

  // don't-care fields carry random bits
  function automatic request_t blank_request(logic [1:0] cmd);
    request_t rq;
    rq.cmd = cmd;
    rq.idx = 8'($urandom);
    rq.opc = 4'($urandom);
    rq.arg = $urandom;
    rq.len = 9'($urandom);
    rq.pid = 6'($urandom);
    rq.cap = $urandom;
    return rq;
  endfunction

  task automatic send_request(request_t rq);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rq.cmd;
    s_axis_tdata  <= {5'b0, rq.cap, rq.pid, rq.len, rq.arg, rq.opc, rq.idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (!(rq.cmd == CMD_WRITE && slots_used >= NP)) items_sent++;
    pending_responses.push_back(predict_response(rq));
  endtask

  task automatic send_write(logic [7:0] idx, logic [3:0] op, logic [31:0] arg);
    request_t rq;
    rq     = blank_request(CMD_WRITE);
    rq.idx = idx;
    rq.opc = op;
    rq.arg = arg;
    send_request(rq);
  endtask

  task automatic send_commit(logic [8:0] len);
    request_t rq;
    rq     = blank_request(CMD_COMMIT);
    rq.len = len;
    send_request(rq);
  endtask

  task automatic send_exec(logic [5:0] pid, logic [31:0] cap);
    request_t rq;
    rq     = blank_request(CMD_EXEC);
    rq.pid = pid;
    rq.cap = cap;
    send_request(rq);
  endtask

  task automatic random_exec();
    logic [5:0] pid;
    if (slots_used > 0 && $urandom_range(0, 6) != 0) pid = 6'($urandom_range(1, slots_used));
    else pid = 6'($urandom_range(0, 63));
    send_exec(pid, pick_capability());
  endtask

  task automatic drain_responses();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_responses.size() != 0);
  endtask

  // writes every instruction in the list before the commit, which may give a longer length
  task automatic load_program(logic [3:0] ops[$], logic [31:0] args[$], logic [8:0] len,
                              bit mixed);
    int order[$];
    int j;
    int t;
    for (int i = 0; i < ops.size(); i++) order.push_back(i);
    if (mixed) begin
      for (int k = ops.size() - 1; k > 0; k--) begin
        j        = $urandom_range(0, k);
        t        = order[k];
        order[k] = order[j];
        order[j] = t;
      end
    end
    foreach (order[k]) begin
      if (mixed && $urandom_range(0, 7) == 0) random_exec();
      if (mixed && $urandom_range(0, 9) == 0) send_write(8'(order[k]), 4'($urandom), $urandom);
      send_write(8'(order[k]), ops[order[k]], args[order[k]]);
    end
    send_commit(len);
  endtask

  task automatic build_random_policy();
    int          n;
    int          len_eff;
    bit          sat;
    logic [8:0]  len;
    logic [3:0]  op;
    logic [31:0] a;
    logic [3:0]  ops[$];
    logic [31:0] args[$];
    n       = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    sat     = ($urandom_range(0, 9) == 0);
    len     = sat ? 9'($urandom_range(PD, 511)) : 9'(n);
    len_eff = sat ? PD : n;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 3) op = 4'($urandom_range(13, 15));
      else op = 4'($urandom_range(0, 12));
      // saturated length: stop before the unwritten tail
      if (sat && i == n - 1) op = OP_HALT;
      if (op inside {OP_JUMP, OP_JUMP_IF, OP_JUMP_IFN}) a = jump_target(i, n, len_eff);
      else a = pick_operand();
      ops.push_back(op);
      args.push_back(a);
    end
    load_program(ops, args, len, 1'b1);
  endtask

  task automatic test_bad_requests();
    request_t rq;
    send_exec(6'd0, $urandom);
    send_exec(6'd63, 32'hFFFF_FFFF);
    send_exec(6'd1, 32'h0);
    rq = blank_request(CMD_UNUSED);
    send_request(rq);
  endtask

  task automatic test_opcode_walk();
    logic [3:0]  ops[$];
    logic [31:0] args[$];
    ops  = '{OP_NOP, OP_MARK, OP_SET_FLAG, OP_JUMP_IF, OP_CAP_MATCH, OP_JUMP_IFN,
             OP_GRANT, OP_HALT, OP_CMP_LT, OP_JUMP_IF, OP_CMP_GT, OP_JUMP_IFN,
             OP_GRANT, OP_JUMP, OP_DENY, OP_CMP_EQ};
    args = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 32'd8,
             32'h0, 32'h0, 32'h10, 32'd12, 32'h8000_0000, 32'd14,
             32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0};
    load_program(ops, args, 9'd16, 1'b0);
    send_exec(6'd1, 32'hDEAD_BEEF);
    send_exec(6'd1, 32'h0);
    send_exec(6'd1, 32'h10);
    send_exec(6'd1, 32'h8000_0000);
    send_exec(6'd1, 32'hFFFF_FFFF);
  endtask

  task automatic test_step_limit();
    logic [3:0]  ops[$];
    logic [31:0] args[$];
    ops  = '{OP_JUMP};
    args = '{32'h0};
    load_program(ops, args, 9'd1, 1'b0);
    send_exec(6'(slots_used), $urandom);
  endtask

  task automatic test_edge_lengths();
    logic [3:0]  ops[$];
    logic [31:0] args[$];
    // empty program
    send_commit(9'd0);
    send_exec(6'(slots_used), $urandom);
    // invalid opcodes on both branches
    ops  = '{OP_CMP_EQ, OP_JUMP_IF, OP_BAD_LO, OP_BAD_HI};
    args = '{32'd7, 32'd3, 32'h0, 32'h0};
    load_program(ops, args, 9'd4, 1'b0);
    send_exec(6'(slots_used), 32'd7);
    send_exec(6'(slots_used), 32'd8);
    // length beyond depth saturates
    ops  = '{OP_GRANT, OP_HALT};
    args = '{32'h0, 32'h0};
    load_program(ops, args, 9'h1FF, 1'b0);
    send_exec(6'(slots_used), $urandom);
    send_exec(6'(slots_used + 1), $urandom);
  endtask

  task automatic test_random_traffic();
    int       stop_at;
    int       sel;
    request_t rq;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0) quiet = !quiet;
      if ($urandom_range(0, 149) == 0) drain_responses();
      sel = $urandom_range(0, 99);
      if (slots_used < NP && sel < 30) begin
        build_random_policy();
      end else if (sel < 85) begin
        random_exec();
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
          rq = blank_request(CMD_UNUSED);
          send_request(rq);
        end else if (sel < 75) begin
          rq = blank_request(CMD_WRITE);
          send_request(rq);
        end else if (slots_used >= NP) begin
          rq = blank_request(CMD_COMMIT);
          send_request(rq);
        end else begin
          send_exec(6'($urandom_range(0, 63)), pick_capability());
        end
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_store_full();
    logic [3:0]  ops[$];
    logic [31:0] args[$];
    ops  = '{OP_GRANT};
    args = '{32'h0};
    while (slots_used < NP) load_program(ops, args, 9'd1, 1'b0);
    send_commit(9'd1);
    send_commit(9'h100);
    send_write(8'd0, OP_DENY, 32'h0);
    send_write(8'hFF, OP_BAD_HI, 32'hFFFF_FFFF);
    send_exec(6'(NP), $urandom);
    send_exec(6'(NP + 1), $urandom);
    send_exec(6'd1, 32'hDEAD_BEEF);
  endtask

  task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    response_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_responses.size() == 0) begin
        $display("%0t unexpected response: expected none actual %h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_responses.pop_front();
        compare_field("verdict", 32'(want.verdict), 32'(m_axis_tdata[1:0]));
        compare_field("assigned_id", 32'(want.id), 32'(m_axis_tdata[7:2]));
        compare_field("execution_count", want.runs, m_axis_tdata[39:8]);
        compare_field("error_count", want.errs, m_axis_tdata[71:40]);
        compare_field("compile_count", want.commits, m_axis_tdata[103:72]);
      end
    end
  end

  // output back-pressure
  initial begin
    int g;
    m_axis_tready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      g = pick_gap();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("[policy_bytecode_interpreter] ERROR");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_bad_requests();
    drain_responses();
    test_opcode_walk();
    test_step_limit();
    drain_responses();
    test_edge_lengths();
    drain_responses();
    test_random_traffic();
    drain_responses();
    test_store_full();
    drain_responses();
    repeat (64) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[policy_bytecode_interpreter] OK");
    end else begin
      $display("[policy_bytecode_interpreter] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pbi_pkg.sv
hw/rtl/pbi_front.sv
hw/rtl/pbi_queue.sv
hw/rtl/pbi_back.sv
hw/rtl/policy_bytecode_interpreter.sv
hw/rtl/pbi_checker.sv
tb/sv/tb_policy_bytecode_interpreter.sv
